// ----- rtl/work_stealing_deque_defines.svh -----
// Assertion macros shared by the checker of the work-stealing deque.
// Depends on nothing; the using module must provide clk_i and rst_ni.
`ifndef WORK_STEALING_DEQUE_DEFINES_SVH
`define WORK_STEALING_DEQUE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WSD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define WSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/wsd_pkg.sv -----
// Shared types and constants of the work-stealing deque.
// No dependencies; imported by the cell, the top level and the checker.
package wsd_pkg;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned FIELD_W  = 32;
  localparam int unsigned COUNT_W  = 7;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_STEAL = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Shift commands broadcast to every cell of the chain.
  typedef struct packed {
    logic push;
    logic pop;
    logic steal;
  } wsd_ctl_t;

endpackage

// ----- rtl/wsd_cell.sv -----
// One storage cell of the deque chain: an entry and its occupancy bit.
// Depends on wsd_pkg for the shift command struct.
module wsd_cell #(
  parameter int unsigned W = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  wsd_pkg::wsd_ctl_t ctl_i,
  input  logic [W-1:0]      below_data_i,
  input  logic              below_occ_i,
  input  logic [W-1:0]      above_data_i,
  input  logic              above_occ_i,
  output logic [W-1:0]      data_o,
  output logic              occ_o,
  output logic [W-1:0]      tap_o
);
  import wsd_pkg::*;

  logic [W-1:0] data_q, data_d;
  logic         occ_q, occ_d;

  always_comb begin
    data_d = data_q;
    occ_d  = occ_q;
    if (ctl_i.push) begin
      data_d = below_data_i;
      occ_d  = below_occ_i;
    end else if (ctl_i.pop) begin
      data_d = above_data_i;
      occ_d  = above_occ_i;
    end else if (ctl_i.steal) begin
      // The entries stay put; the occupancy edge drops by one cell.
      occ_d = above_occ_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign occ_o  = occ_q;
  // Only the oldest entry, where occupancy ends, shows its data on the tap.
  assign tap_o  = (occ_q && !above_occ_i) ? data_q : '0;

endmodule

// ----- rtl/wsd_tree.sv -----
// Pipelined OR tree that gathers the single tapped cell onto one word.
// No package dependency; one register level per halving.
module wsd_tree #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned W     = 32
) (
  input  logic         clk_i,
  input  logic [W-1:0] leaf_i [DEPTH],
  output logic [W-1:0] root_o
);

  // Heap numbering: node n has children 2n and 2n+1, leaves sit at DEPTH and up.
  logic [W-1:0] node_q [1:DEPTH-1];
  logic [W-1:0] node_w [1:2*DEPTH-1];

  always_comb begin
    for (int unsigned n = 1; n < DEPTH; n++) begin
      node_w[n] = node_q[n];
    end
    for (int unsigned i = 0; i < DEPTH; i++) begin
      node_w[DEPTH+i] = leaf_i[i];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int unsigned n = 1; n < DEPTH; n++) begin
      node_q[n] <= node_w[2*n] | node_w[2*n+1];
    end
  end

  assign root_o = node_q[1];

endmodule

// ----- rtl/work_stealing_deque.sv -----
// Work-stealing deque of DEPTH task handles held in a chain of cells, newest entry in
// cell 0; depends on wsd_pkg, wsd_cell and wsd_tree. A transaction is taken when start
// is high and busy is low, and its result appears on the output ports for exactly one
// cycle with done_o high; the receiver cannot stall it. Push, pop, the empty and full
// refusals and the unused code give their result in the next cycle. A successful steal
// waits while the registered OR tree collects the oldest entry from the far end of the
// chain; busy stays high meanwhile. No clearing pass follows reset: entries are only
// read after they were written.
module work_stealing_deque #(
  parameter int unsigned DEPTH      = 64,
  parameter int unsigned ITEM_WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [wsd_pkg::OP_W-1:0]     operation_i,
  input  logic [wsd_pkg::FIELD_W-1:0]  item_in_i,
  output logic                         done_o,
  output logic [wsd_pkg::FIELD_W-1:0]  item_out_o,
  output logic [wsd_pkg::STATUS_W-1:0] status_o,
  output logic [wsd_pkg::COUNT_W-1:0]  count_o
);
  import wsd_pkg::*;

  localparam int unsigned CW     = $clog2(DEPTH) + 1;
  localparam int unsigned LEVELS = $clog2(DEPTH);
  localparam int unsigned WAIT_W = $clog2(LEVELS + 1);

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_STEAL = 2'b10
  } state_e;

  state_e            state_q, state_d;
  logic [WAIT_W-1:0] wait_q, wait_d;
  logic [CW-1:0]     count_q, count_d;
  logic              done_q, done_d;
  logic [FIELD_W-1:0] item_q, item_d;
  status_e           status_q, status_d;
  logic [CW-1:0]     res_count_q, res_count_d;

  wsd_ctl_t          ctl;
  logic              accept;
  logic              is_empty, is_full;

  logic [ITEM_WIDTH-1:0] item_st;
  logic [FIELD_W+ITEM_WIDTH-1:0] in_ext;
  logic [FIELD_W+ITEM_WIDTH-1:0] pop_ext;
  logic [FIELD_W+ITEM_WIDTH-1:0] root_ext;
  logic [CW+COUNT_W-1:0]         cnt_ext;

  logic [ITEM_WIDTH-1:0] cell_data [DEPTH];
  logic                  cell_occ  [DEPTH];
  logic [ITEM_WIDTH-1:0] cell_tap  [DEPTH];
  logic [ITEM_WIDTH-1:0] root;

  assign in_ext  = (FIELD_W+ITEM_WIDTH)'(item_in_i);
  assign item_st = in_ext[ITEM_WIDTH-1:0];
  assign pop_ext  = (FIELD_W+ITEM_WIDTH)'(cell_data[0]);
  assign root_ext = (FIELD_W+ITEM_WIDTH)'(root);

  assign busy     = (state_q == S_STEAL);
  assign accept   = start && !busy;
  assign is_empty = (count_q == '0);
  assign is_full  = (count_q == CW'(DEPTH));

  always_comb begin
    state_d     = state_q;
    wait_d      = wait_q;
    count_d     = count_q;
    done_d      = 1'b0;
    item_d      = item_q;
    status_d    = status_q;
    res_count_d = res_count_q;
    ctl         = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          done_d      = 1'b1;
          item_d      = '0;
          status_d    = ST_OK;
          res_count_d = count_q;
          case (op_e'(operation_i))
            OP_PUSH: begin
              if (is_full) begin
                status_d = ST_FULL;
              end else begin
                ctl.push    = 1'b1;
                count_d     = count_q + CW'(1);
                res_count_d = count_q + CW'(1);
              end
            end
            OP_POP: begin
              if (is_empty) begin
                status_d = ST_EMPTY;
              end else begin
                ctl.pop     = 1'b1;
                item_d      = pop_ext[FIELD_W-1:0];
                count_d     = count_q - CW'(1);
                res_count_d = count_q - CW'(1);
              end
            end
            OP_STEAL: begin
              if (is_empty) begin
                status_d = ST_EMPTY;
              end else begin
                // The oldest entry climbs the registered levels of the OR tree to the root.
                ctl.steal   = 1'b1;
                done_d      = 1'b0;
                count_d     = count_q - CW'(1);
                res_count_d = count_q - CW'(1);
                wait_d      = WAIT_W'(LEVELS - 1);
                state_d     = S_STEAL;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_STEAL: begin
        if (wait_q == '0) begin
          done_d  = 1'b1;
          item_d  = root_ext[FIELD_W-1:0];
          state_d = S_IDLE;
        end else begin
          wait_d = wait_q - WAIT_W'(1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      wait_q  <= '0;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      wait_q  <= wait_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q      <= item_d;
    status_q    <= status_d;
    res_count_q <= res_count_d;
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ITEM_WIDTH-1:0] below_data, above_data;
    logic                  below_occ, above_occ;

    if (i == 0) begin : g_first
      assign below_data = item_st;
      assign below_occ  = 1'b1;
    end else begin : g_inner_lo
      assign below_data = cell_data[i-1];
      assign below_occ  = cell_occ[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign above_data = '0;
      assign above_occ  = 1'b0;
    end else begin : g_inner_hi
      assign above_data = cell_data[i+1];
      assign above_occ  = cell_occ[i+1];
    end

    wsd_cell #(
      .W (ITEM_WIDTH)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ctl),
      .below_data_i (below_data),
      .below_occ_i  (below_occ),
      .above_data_i (above_data),
      .above_occ_i  (above_occ),
      .data_o       (cell_data[i]),
      .occ_o        (cell_occ[i]),
      .tap_o        (cell_tap[i])
    );
  end

  wsd_tree #(
    .DEPTH (DEPTH),
    .W     (ITEM_WIDTH)
  ) u_tree (
    .clk_i  (clk_i),
    .leaf_i (cell_tap),
    .root_o (root)
  );

  assign cnt_ext    = (CW+COUNT_W)'(res_count_q);
  assign done_o     = done_q;
  assign item_out_o = item_q;
  assign status_o   = status_q;
  assign count_o    = cnt_ext[COUNT_W-1:0];

endmodule

// ----- rtl/wsd_checker.sv -----
// Port-level checker for the work-stealing deque, bound to the top level.
// Depends on wsd_pkg and the macros in work_stealing_deque_defines.svh.
`include "work_stealing_deque_defines.svh"

module wsd_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         start,
  input logic                         busy,
  input logic [wsd_pkg::OP_W-1:0]     operation_i,
  input logic                         done_o,
  input logic [wsd_pkg::FIELD_W-1:0]  item_out_o,
  input logic [wsd_pkg::STATUS_W-1:0] status_o,
  input logic [wsd_pkg::COUNT_W-1:0]  count_o
);
  import wsd_pkg::*;

  // Every transaction other than a steal answers in the very next cycle.
  `WSD_ASSERT_NEXT(a_quick_result,
                   start && !busy && operation_i != OP_STEAL,
                   done_o,
                   "result of a one-cycle transaction missing")

  // An empty answer leaves nothing in the queue and returns no handle.
  `WSD_ASSERT_NOW(a_empty_result,
                  done_o && status_o == ST_EMPTY,
                  item_out_o == '0 && count_o == '0,
                  "empty result carries data or a count")

  // A refused push returns no handle.
  `WSD_ASSERT_NOW(a_full_result,
                  done_o && status_o == ST_FULL,
                  item_out_o == '0,
                  "full result carries data")

  // The block only turns busy after it has taken a steal.
  `WSD_ASSERT_NOW(a_busy_cause,
                  $rose(busy),
                  $past(start) && $past(operation_i) == OP_STEAL,
                  "busy raised without a steal")

endmodule

bind work_stealing_deque wsd_checker u_wsd_checker (.*);
